### hdl/sbdt_pkg.sv
// Package for the shared buffer dynamic threshold unit.
// Holds item and result types, op codes and register indexes; no dependencies.
package sbdt_pkg;

    localparam int unsigned BYTES_W = 24;
    localparam int unsigned THR_W   = 25;
    localparam int unsigned ALPHA_W = 7;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned PORT_W  = 4;
    localparam int unsigned NUM_W   = ALPHA_W + BYTES_W;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTES_W-1:0] RESET_MAX_BYTES = 24'd9000000;
    localparam logic [THR_W-1:0]   RESET_THRESHOLD = 25'd18000000;
    localparam logic [ALPHA_W-1:0] RESET_ALPHA     = 7'd2;
    localparam logic [TICK_W-1:0]  RESET_PERIOD    = 16'd1000;
    localparam logic [THR_W-1:0]   THR_SAT         = '1;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_DEPART = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BYTES = 2'd0,
        CFG_ALPHA     = 2'd1,
        CFG_PERIOD    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        op;
        logic [PORT_W-1:0] port;
        logic [SIZE_W-1:0] size_bytes;
    } t_item;

    typedef struct packed {
        logic               admitted;
        logic [BYTES_W-1:0] port_used;
        logic [BYTES_W-1:0] total_used;
        logic [THR_W-1:0]   threshold_now;
    } t_result;

endpackage

### hdl/sbdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbdt_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/shared_buffer_dynamic_threshold_unit.sv
// Top level of the shared buffer admission unit with dynamic per-port threshold.
// Uses sbdt_pkg and two sbdt_ram instances (port byte counts, idle timers).
//
// Usage:
//   Input channel: present i_item with i_start high; the item is taken at an
//   edge where i_start is high and o_busy is low.
//   Result channel: o_result is valid for exactly one cycle while o_done is
//   high. There is no back pressure; the receiver must take it then.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 max buffer bytes, 1 alpha, 2 period ticks); write only while idle.
// Sequence:
//   Arrival, departure and unused ops: one RAM read followed by one
//   read-modify-write step.
//   Tick: one RAM read, a sweep over the PORTS entries of the timer RAM and
//   a finish step, with a multiply step and the bit-serial divider between
//   them when the threshold recalculation runs.
//   A new item may be started in the cycle its predecessor's result shows.
// Reset: synchronous active low; counts, flags and timers read as zero,
//   threshold as twice the reset buffer size, registers take reset values.
module shared_buffer_dynamic_threshold_unit #(
    parameter int unsigned PORTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  sbdt_pkg::t_item                i_item,
    output logic                           o_done,
    output sbdt_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [sbdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sbdt_pkg::BYTES_W-1:0]   i_cfg_data
);
    import sbdt_pkg::*;

    localparam int unsigned PW  = $clog2(PORTS);
    localparam int unsigned CW  = PW + 1;
    localparam int unsigned SW  = BYTES_W + PW;
    localparam int unsigned DW  = CW + ALPHA_W + 1;
    localparam int unsigned DCW = $clog2(NUM_W + 1);
    localparam int unsigned IW  = TICK_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RMW, S_SWEEP, S_MUL, S_DIV, S_FIN
    } t_state;

    t_state               r_state;
    logic [BYTES_W-1:0]   r_max;
    logic [ALPHA_W-1:0]   r_alpha;
    logic [TICK_W-1:0]    r_period;
    logic [BYTES_W-1:0]   r_total;
    logic [THR_W-1:0]     r_thr;
    logic [TICK_W-1:0]    r_rcount;
    logic                 r_run;
    logic                 r_do_recalc;
    logic [PORTS-1:0]     r_bv;
    logic [PORTS-1:0]     r_iv;
    logic                 r_bv_q;
    logic                 r_iv_q;
    t_item                r_item;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_act;
    logic [SW-1:0]        r_idle_sum;
    logic [BYTES_W-1:0]   r_pu;
    logic [NUM_W-1:0]     r_quo;
    logic [DW-1:0]        r_den;
    logic [DW-1:0]        r_rem;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_done;
    t_result              r_result;

    logic                 w_accept;
    logic [PW-1:0]        w_raddr;
    logic [PW-1:0]        w_item_addr;
    logic                 w_item_ok;
    logic [BYTES_W-1:0]   w_bytes_rd;
    logic [BYTES_W-1:0]   w_bytes_q;
    logic [IW-1:0]        w_idle_rd;
    logic [IW-1:0]        w_idle_q;
    logic                 w_b_we;
    logic [PW-1:0]        w_b_waddr;
    logic [BYTES_W-1:0]   w_b_wdata;
    logic                 w_i_we;
    logic [PW-1:0]        w_i_waddr;
    logic [IW-1:0]        w_i_wdata;
    logic [PW-1:0]        w_sw_addr;
    logic [IW-1:0]        w_sw_idle;
    logic                 w_sw_last;
    logic [THR_W:0]       w_port_sum;
    logic [BYTES_W:0]     w_total_sum;
    logic                 w_admit;
    logic [BYTES_W-1:0]   w_rem_bytes;
    logic [BYTES_W-1:0]   w_room;
    logic [DW:0]          w_rem_sh;
    logic                 w_ge;
    logic [THR_W-1:0]     w_thr_new;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_item_addr = PW'(r_item.port);
    assign w_item_ok   = 32'(r_item.port) < PORTS;
    assign w_raddr     = (r_state == S_SWEEP) ? r_idx[PW-1:0] :
                         (i_item.op == OP_TICK) ? '0 : PW'(i_item.port);

    sbdt_ram #(.WIDTH(BYTES_W), .DEPTH(PORTS)) u_bytes_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_bytes_rd)
    );

    sbdt_ram #(.WIDTH(IW), .DEPTH(PORTS)) u_idle_ram (
        .i_clk   (i_clk),
        .i_we    (w_i_we),
        .i_waddr (w_i_waddr),
        .i_wdata (w_i_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_idle_rd)
    );

    assign w_bytes_q = r_bv_q ? w_bytes_rd : '0;
    assign w_idle_q  = r_iv_q ? w_idle_rd : '0;

    assign w_port_sum  = (THR_W+1)'(w_bytes_q) + (THR_W+1)'(r_item.size_bytes);
    assign w_total_sum = (BYTES_W+1)'(r_total) + (BYTES_W+1)'(r_item.size_bytes);
    assign w_admit     = w_item_ok && (r_item.op == OP_ARRIVE)
                         && (w_total_sum <= (BYTES_W+1)'(r_max))
                         && (w_port_sum <= (THR_W+1)'(r_thr));
    assign w_rem_bytes = (BYTES_W'(r_item.size_bytes) < w_bytes_q) ?
                         BYTES_W'(r_item.size_bytes) : w_bytes_q;

    assign w_sw_addr = PW'(r_idx - CW'(1));
    assign w_sw_last = (r_idx == CW'(PORTS));
    always_comb begin
        w_sw_idle = w_idle_q;
        if (w_idle_q[TICK_W]) begin
            if (w_idle_q[TICK_W-1:0] <= TICK_W'(1)) begin
                w_sw_idle = '0;
            end else begin
                w_sw_idle = {1'b1, w_idle_q[TICK_W-1:0] - TICK_W'(1)};
            end
        end
    end

    always_comb begin
        w_b_we    = 1'b0;
        w_b_waddr = w_item_addr;
        w_b_wdata = w_bytes_q;
        w_i_we    = 1'b0;
        w_i_waddr = w_item_addr;
        w_i_wdata = {1'b1, r_period};
        if (r_state == S_RMW && w_item_ok) begin
            if (w_admit) begin
                w_b_we    = 1'b1;
                w_b_wdata = w_port_sum[BYTES_W-1:0];
                w_i_we    = 1'b1;
            end else if (r_item.op == OP_DEPART) begin
                w_b_we    = 1'b1;
                w_b_wdata = w_bytes_q - w_rem_bytes;
            end
        end else if (r_state == S_SWEEP) begin
            w_i_we    = 1'b1;
            w_i_waddr = w_sw_addr;
            w_i_wdata = w_sw_idle;
        end
    end

    assign w_room = (r_idle_sum > SW'(r_max)) ? '0 :
                    (r_max - r_idle_sum[BYTES_W-1:0]);

    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_ge     = w_rem_sh >= (DW+1)'(r_den);
    assign w_thr_new = (r_quo[NUM_W-1:THR_W] != '0) ? THR_SAT : r_quo[THR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= RESET_MAX_BYTES;
            r_alpha     <= RESET_ALPHA;
            r_period    <= RESET_PERIOD;
            r_total     <= '0;
            r_thr       <= RESET_THRESHOLD;
            r_rcount    <= '0;
            r_run       <= 1'b0;
            r_do_recalc <= 1'b0;
            r_bv        <= '0;
            r_iv        <= '0;
            r_bv_q      <= 1'b0;
            r_iv_q      <= 1'b0;
            r_idx       <= '0;
            r_act       <= '0;
            r_idle_sum  <= '0;
            r_dcnt      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_bv_q <= r_bv[w_raddr];
            r_iv_q <= r_iv[w_raddr];
            if (w_b_we) begin
                r_bv[w_b_waddr] <= 1'b1;
            end
            if (w_i_we) begin
                r_iv[w_i_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_BYTES: r_max    <= i_cfg_data;
                    CFG_ALPHA:     r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                    CFG_PERIOD:    r_period <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_item;
                        if (i_item.op == OP_TICK) begin
                            r_state     <= S_SWEEP;
                            r_idx       <= CW'(1);
                            r_act       <= '0;
                            r_idle_sum  <= '0;
                            r_pu        <= '0;
                            r_do_recalc <= 1'b0;
                            if (r_run) begin
                                if (r_rcount <= TICK_W'(1)) begin
                                    r_rcount    <= '0;
                                    r_do_recalc <= 1'b1;
                                end else begin
                                    r_rcount <= r_rcount - TICK_W'(1);
                                end
                            end
                        end else begin
                            r_state <= S_RMW;
                        end
                    end
                end
                S_RMW: begin
                    r_state                 <= S_IDLE;
                    r_done                  <= 1'b1;
                    r_result.admitted       <= w_admit;
                    r_result.threshold_now  <= r_thr;
                    r_result.port_used      <= w_item_ok ? w_bytes_q : '0;
                    r_result.total_used     <= r_total;
                    if (w_admit) begin
                        r_total                <= w_total_sum[BYTES_W-1:0];
                        r_result.port_used     <= w_port_sum[BYTES_W-1:0];
                        r_result.total_used    <= w_total_sum[BYTES_W-1:0];
                        if (!r_run) begin
                            r_run    <= 1'b1;
                            r_rcount <= r_period;
                        end
                    end else if (r_item.op == OP_DEPART && w_item_ok) begin
                        r_result.port_used <= w_bytes_q - w_rem_bytes;
                        r_total            <= (w_rem_bytes < r_total) ?
                                              r_total - w_rem_bytes : '0;
                        r_result.total_used <= (w_rem_bytes < r_total) ?
                                               r_total - w_rem_bytes : '0;
                    end
                end
                S_SWEEP: begin
                    r_idx <= r_idx + CW'(1);
                    if (w_sw_idle[TICK_W]) begin
                        r_act <= r_act + CW'(1);
                    end else begin
                        r_idle_sum <= r_idle_sum + SW'(w_bytes_q);
                    end
                    if (w_item_ok && w_sw_addr == w_item_addr) begin
                        r_pu <= w_bytes_q;
                    end
                    if (w_sw_last) begin
                        r_state <= r_do_recalc ? S_MUL : S_FIN;
                    end
                end
                S_MUL: begin
                    r_quo   <= NUM_W'(r_alpha * w_room);
                    r_den   <= DW'(1) + DW'(r_act * r_alpha);
                    r_rem   <= '0;
                    r_dcnt  <= DCW'(NUM_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_ge ? DW'(w_rem_sh - (DW+1)'(r_den)) : DW'(w_rem_sh);
                    r_quo  <= {r_quo[NUM_W-2:0], w_ge};
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (r_do_recalc) begin
                        r_thr                  <= w_thr_new;
                        r_result.threshold_now <= w_thr_new;
                        if (r_act == '0) begin
                            r_run <= 1'b0;
                        end else begin
                            r_rcount <= r_period;
                        end
                    end else begin
                        r_result.threshold_now <= r_thr;
                    end
                    r_result.admitted   <= 1'b0;
                    r_result.port_used  <= r_pu;
                    r_result.total_used <= r_total;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done)
        else $error("busy dropped without a result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_act) <= PORTS)
        else $error("active port count out of range");

    a_admit_arrive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.admitted) |-> $past(r_item.op == OP_ARRIVE))
        else $error("admitted set for a non-arrival");
endmodule
